// File: rtl/core/aaee_pkg.sv
// Shared types and constants for the argument area escape encoder.
// Holds the input codes, the write descriptor passed from front to back,
// and the constant text tables. No dependencies.
`timescale 1ns / 1ps

package aaee_pkg;

  // Input item kinds carried on in_tuser.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_FAIL  = 2'd2;

  // Configuration register indexes (paddr[3:2]).
  localparam logic [1:0] REG_ARG_COUNT = 2'd0;
  localparam logic [1:0] REG_ENV_COUNT = 2'd1;
  localparam logic [1:0] REG_HDR_LEN   = 2'd2;

  // Characters.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_DEL    = 8'd127;

  // Lengths of the fixed text pieces.
  localparam int ELL_LEN = 4;   // "... "
  localparam int SEP_LEN = 11;  // "} envp[]={ "
  localparam int FIN_LEN = 2;   // "}" and terminator

  // Queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // One accepted item, fully classified: a short explicit byte group A
  // (opening quote plus escaped byte) and a tail group B made of the fixed
  // pieces, each group at consecutive positions.
  typedef struct packed {
    logic [2:0]       a_n;
    logic [4:0][7:0]  a_bytes;
    logic [12:0]      pos_a;
    logic [12:0]      pos_b;
    logic             ell;
    logic             sep;
    logic             fin;
    logic [4:0]       n;
    logic             finished;
    logic             failed;
    logic [12:0]      final_length;
    logic [15:0]      args_left;
    logic [15:0]      env_left;
  } desc_t;

  function automatic logic [7:0] sep_char(input logic [3:0] i);
    logic [7:0] ch;
    case (i)
      4'd0:    ch = 8'h7D;  // }
      4'd1:    ch = 8'h20;
      4'd2:    ch = 8'h65;  // e
      4'd3:    ch = 8'h6E;  // n
      4'd4:    ch = 8'h76;  // v
      4'd5:    ch = 8'h70;  // p
      4'd6:    ch = 8'h5B;  // [
      4'd7:    ch = 8'h5D;  // ]
      4'd8:    ch = 8'h3D;  // =
      4'd9:    ch = 8'h7B;  // {
      4'd10:   ch = 8'h20;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Byte k of the tail group: optional ellipsis, optional separator, then
  // the closing brace and the terminator.
  function automatic logic [7:0] tail_byte(input logic [4:0] k, input logic ell,
                                           input logic sep);
    logic [4:0] j;
    logic [4:0] m;
    logic [7:0] ch;
    j = ell ? (k - 5'(ELL_LEN)) : k;
    m = sep ? (j - 5'(SEP_LEN)) : j;
    if (ell && (k < 5'(ELL_LEN))) begin
      ch = (k == 5'(ELL_LEN - 1)) ? CH_SPACE : CH_DOT;
    end else if (sep && (j < 5'(SEP_LEN))) begin
      ch = sep_char(j[3:0]);
    end else begin
      ch = (m == 5'd0) ? CH_RBRACE : 8'h00;
    end
    return ch;
  endfunction

endpackage

// File: rtl/core/argument_area_escape_encoder_top.sv
// Top level of the argument area escape encoder: configuration registers
// and the front end, descriptor queue and write sequencer.
// Depends on aaee_pkg, aaee_front, aaee_fifo and aaee_back.
`timescale 1ns / 1ps

// The block turns the raw bytes of a process argument area into quoted,
// escaped text, delivered as a stream of buffer writes (position, byte).
// Software programs the argument count, environment count and header length,
// then sends a start beat followed by one beat per raw byte. The front end
// takes one input beat per clock whenever the four-entry descriptor queue
// has room; it updates the write pointer and the string counters in that
// same cycle. The write sequencer then emits one result beat per clock,
// unless the output is stalled, for each buffer write the byte caused:
// one write for a printable byte, two for a backslash or a string end, four
// for an octal escape, one more when the byte opens a string and needs the
// opening quote, and up to eighteen when a string end closes a list
// (ellipsis, envp separator, closing brace and terminator). A byte that
// writes nothing still yields one status beat with write_valid low. The
// last beat caused by an input beat carries tlast, and every beat carries
// the status after that input: finished, failed, final length and the
// remaining string counts. Configuration must be written while the stream
// is idle; the block itself does not enforce this.

module argument_area_escape_encoder_top import aaee_pkg::*; #(
  parameter int BUFFER_BYTES  = 8192,
  parameter int RESERVE_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [1:0] op
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [12:0] write_position, [20:13] write_byte,
                                  // [21] finished, [22] failed,
                                  // [35:23] final_length,
                                  // [51:36] arguments_remaining,
                                  // [67:52] environment_remaining, [71:68] zero
  output logic        out_tuser,  // [0] write_valid
  output logic        out_tlast,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] arg_count_r;
  logic [15:0] env_count_r;
  logic [7:0]  hdr_len_r;
  logic        cfg_wr;

  logic        q_full, q_push, q_pop, q_valid;
  desc_t       q_din, q_dout;

  // Register file: one register per word, written on the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arg_count_r <= '0;
      env_count_r <= '0;
      hdr_len_r   <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ARG_COUNT: arg_count_r <= pwdata[15:0];
        REG_ENV_COUNT: env_count_r <= pwdata[15:0];
        REG_HDR_LEN:   hdr_len_r   <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ARG_COUNT: prdata = {16'd0, arg_count_r};
      REG_ENV_COUNT: prdata = {16'd0, env_count_r};
      REG_HDR_LEN:   prdata = {24'd0, hdr_len_r};
      default:       prdata = 32'd0;
    endcase
  end

  // Front end: classifies each beat and computes its writes.
  aaee_front #(
    .BUFFER_BYTES  (BUFFER_BYTES),
    .RESERVE_BYTES (RESERVE_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .arg_count (arg_count_r),
    .env_count (env_count_r),
    .hdr_len   (hdr_len_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_desc    (q_din)
  );

  // Descriptor queue lets the input keep flowing while long write bursts
  // drain on the output side.
  aaee_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  // Write sequencer: one buffer write per output beat.
  aaee_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_desc     (q_dout),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// File: rtl/core/aaee_front.sv
// Front end of the escape encoder: accepts items, keeps the string counters
// and the write pointer, and turns each item into one write descriptor.
// Depends on aaee_pkg.
`timescale 1ns / 1ps

module aaee_front import aaee_pkg::*; #(
  parameter int BUFFER_BYTES  = 8192,
  parameter int RESERVE_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic [15:0] arg_count,
  input  logic [15:0] env_count,
  input  logic [7:0]  hdr_len,
  input  logic        q_full,
  output logic        q_push,
  output desc_t       q_desc
);

  localparam int PTRW = $clog2(BUFFER_BYTES) + 1;
  localparam logic [PTRW-1:0] LIMIT = PTRW'(BUFFER_BYTES - RESERVE_BYTES);

  typedef enum logic [1:0] {PH_IDLE, PH_RUN, PH_DONE, PH_FAIL} phase_t;

  phase_t            phase_r, phase_nxt;
  logic [PTRW-1:0]   wp_r, wp_nxt;
  logic [PTRW-1:0]   ss_r, ss_nxt;
  logic [15:0]       al_r, al_nxt;
  logic [15:0]       el_r, el_nxt;
  logic              trunc_r, trunc_nxt;

  logic              accept;
  logic              quote, over, is_nul;
  logic [PTRW-1:0]   p1, wp1, ss1, pos_b, wp_b;
  logic              trunc1;
  logic [2:0]        body_n, a_n;
  logic [3:0][7:0]   body;
  logic              ell, sep, fin;
  desc_t             d;

  function automatic logic [12:0] to_pos(input logic [PTRW-1:0] p);
    logic [PTRW+12:0] e;
    e = {13'd0, p};
    return e[12:0];
  endfunction

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign q_push    = accept;
  assign q_desc    = d;

  // Escape classification of a data byte.
  assign is_nul = (in_tdata == 8'd0);
  assign quote  = (wp_r == ss_r);
  assign p1     = wp_r + PTRW'(quote);
  assign over   = (p1 >= LIMIT);

  always_comb begin
    body   = '0;
    body_n = 3'd0;
    if (over) begin
      body_n = 3'd0;
    end else if (in_tdata == CH_BSLASH) begin
      body[0] = CH_BSLASH;
      body[1] = CH_BSLASH;
      body_n  = 3'd2;
    end else if ((in_tdata > CH_SPACE) && (in_tdata < CH_DEL)) begin
      body[0] = in_tdata;
      body_n  = 3'd1;
    end else if (is_nul) begin
      body[0] = CH_QUOTE;
      body[1] = CH_SPACE;
      body_n  = 3'd2;
    end else begin
      body[0] = CH_BSLASH;
      body[1] = CH_ZERO | {6'd0, in_tdata[7:6]};
      body[2] = CH_ZERO | {5'd0, in_tdata[5:3]};
      body[3] = CH_ZERO | {5'd0, in_tdata[2:0]};
      body_n  = 3'd4;
    end
  end

  assign a_n    = body_n + 3'(quote);
  assign wp1    = wp_r + PTRW'(a_n);
  assign ss1    = (is_nul && !over) ? wp1 : ss_r;
  assign trunc1 = trunc_r || over;

  always_comb begin
    phase_nxt = phase_r;
    wp_nxt    = wp_r;
    ss_nxt    = ss_r;
    al_nxt    = al_r;
    el_nxt    = el_r;
    trunc_nxt = trunc_r;
    ell       = 1'b0;
    sep       = 1'b0;
    fin       = 1'b0;
    pos_b     = wp1;
    wp_b      = wp1;
    d         = '0;

    case (in_tuser)
      OP_START: begin
        al_nxt    = arg_count;
        el_nxt    = env_count;
        trunc_nxt = 1'b0;
        sep       = (arg_count == 16'd0);
        fin       = (arg_count == 16'd0) && (env_count == 16'd0);
        pos_b     = PTRW'(hdr_len);
        wp_b      = PTRW'(hdr_len) + (sep ? PTRW'(SEP_LEN) : '0);
        ss_nxt    = wp_b;
        wp_nxt    = wp_b + PTRW'(fin);
        phase_nxt = fin ? PH_DONE : PH_RUN;
      end
      OP_DATA: begin
        if (phase_r == PH_RUN) begin
          d.a_n     = a_n;
          d.a_bytes = quote ? {body[3:0], CH_QUOTE} : {8'd0, body[3:0]};
          ss_nxt    = ss1;
          trunc_nxt = trunc1;
          if (is_nul) begin
            if (al_r != 16'd0) begin
              al_nxt = al_r - 16'd1;
              if (al_r == 16'd1) begin
                ell       = trunc1;
                sep       = 1'b1;
                pos_b     = trunc1 ? ss1 : wp1;
                wp_b      = pos_b + (trunc1 ? PTRW'(ELL_LEN + SEP_LEN) : PTRW'(SEP_LEN));
                ss_nxt    = wp_b;
                trunc_nxt = 1'b0;
              end
            end else if (el_r != 16'd0) begin
              el_nxt = el_r - 16'd1;
              if ((el_r == 16'd1) && trunc1) begin
                ell   = 1'b1;
                pos_b = ss1;
                wp_b  = ss1 + PTRW'(ELL_LEN);
              end
            end
            fin = (al_nxt == 16'd0) && (el_nxt == 16'd0);
          end
          wp_nxt = wp_b + PTRW'(fin);
          if (fin) begin
            phase_nxt = PH_DONE;
          end
        end
      end
      OP_FAIL: begin
        if (phase_r == PH_RUN) begin
          phase_nxt = PH_FAIL;
        end
      end
      default: begin
      end
    endcase

    d.pos_a        = to_pos(wp_r);
    d.pos_b        = to_pos(pos_b);
    d.ell          = ell;
    d.sep          = sep;
    d.fin          = fin;
    d.n            = 5'(d.a_n) + (ell ? 5'(ELL_LEN) : 5'd0) + (sep ? 5'(SEP_LEN) : 5'd0)
                     + (fin ? 5'(FIN_LEN) : 5'd0);
    d.finished     = (phase_nxt == PH_DONE);
    d.failed       = (phase_nxt == PH_FAIL);
    d.final_length = (phase_nxt == PH_DONE) ? to_pos(wp_nxt) : 13'd0;
    d.args_left    = al_nxt;
    d.env_left     = el_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      wp_r    <= '0;
      ss_r    <= '0;
      al_r    <= '0;
      el_r    <= '0;
      trunc_r <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      wp_r    <= wp_nxt;
      ss_r    <= ss_nxt;
      al_r    <= al_nxt;
      el_r    <= el_nxt;
      trunc_r <= trunc_nxt;
    end
  end

endmodule

// File: rtl/core/aaee_fifo.sv
// Short descriptor queue between the front end and the write sequencer.
// Depends on aaee_pkg for the entry type and the depth.
`timescale 1ns / 1ps

module aaee_fifo import aaee_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t din,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output desc_t dout
);

  desc_t          mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   cnt_r;

  assign full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign valid = (cnt_r != '0);
  assign dout  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

endmodule

// File: rtl/core/aaee_back.sv
// Write sequencer: walks the head descriptor one buffer write per beat and
// drives the registered result channel. Depends on aaee_pkg.
`timescale 1ns / 1ps

module aaee_back import aaee_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  desc_t       q_desc,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,
  output logic        out_tuser,
  output logic        out_tlast
);

  logic [4:0]  idx_r, idx_nxt;
  logic        out_valid_r;
  logic [71:0] out_tdata_r;
  logic        out_tuser_r, out_tlast_r;

  logic        adv, empty, beat_last, in_a;
  logic [4:0]  k;
  logic [12:0] pos;
  logic [7:0]  wbyte;
  logic [71:0] beat_data;

  assign adv       = q_valid && (!out_valid_r || out_tready);
  assign empty     = (q_desc.n == 5'd0);
  assign beat_last = empty || (idx_r == (q_desc.n - 5'd1));
  assign in_a      = (idx_r < 5'(q_desc.a_n));
  assign k         = idx_r - 5'(q_desc.a_n);
  assign q_pop     = adv && beat_last;
  assign idx_nxt   = beat_last ? 5'd0 : (idx_r + 5'd1);

  always_comb begin
    if (empty) begin
      pos   = 13'd0;
      wbyte = 8'd0;
    end else if (in_a) begin
      pos   = q_desc.pos_a + 13'(idx_r);
      wbyte = q_desc.a_bytes[idx_r[2:0]];
    end else begin
      pos   = q_desc.pos_b + 13'(k);
      wbyte = tail_byte(k, q_desc.ell, q_desc.sep);
    end
  end

  assign beat_data = {4'd0, q_desc.env_left, q_desc.args_left, q_desc.final_length,
                      q_desc.failed, q_desc.finished, wbyte, pos};

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= beat_data;
      out_tuser_r <= !empty;
      out_tlast_r <= beat_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        idx_r       <= idx_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for argument_area_escape_encoder_top: a class-based
// write predictor checks every result beat. Depends on aaee_pkg and the RTL.

module tb_top;
  import aaee_pkg::*;

  localparam int BUF_BYTES    = 8192;
  localparam int RESERVE      = 32;
  localparam int FILL_LIMIT   = BUF_BYTES - RESERVE;
  localparam int MAX_WRITES   = 19;
  localparam int DRAIN_SLACK  = 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 4000;
  localparam int PRINT_LIMIT  = 50;
  // The fourth input kind has no meaning; the block must ignore it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {RUN_IDLE, RUN_ACTIVE, RUN_DONE, RUN_FAILED} run_state_t;

  // One result beat, in the order the checker compares the fields.
  typedef struct packed {
    logic        wr;
    logic [12:0] pos;
    logic [7:0]  data;
    logic        last;
    logic        finished;
    logic        failed;
    logic [12:0] flen;
    logic [15:0] args;
    logic [15:0] envs;
  } write_beat_t;

  // Predicts the buffer writes of the encoder and checks the result beats
  // against them in order.
  class escape_writes_checker;
    int unsigned arg_count = 0;
    int unsigned env_count = 0;
    int unsigned hdr_len = 0;
    int unsigned wr_ptr = 0;
    int unsigned seg_start = 0;
    int unsigned args_left = 0;
    int unsigned env_left = 0;
    bit          truncated = 1'b0;
    run_state_t  state = RUN_IDLE;
    logic [12:0] step_pos[$];
    logic [7:0]  step_byte[$];
    write_beat_t expected_writes[$];
    int          errors = 0;

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_ARG_COUNT: arg_count = val[15:0];
        REG_ENV_COUNT: env_count = val[15:0];
        REG_HDR_LEN:   hdr_len = val[7:0];
        default: ;
      endcase
    endfunction

    function void put(logic [7:0] ch);
      if (step_pos.size() < MAX_WRITES) begin
        step_pos.push_back(13'(wr_ptr));
        step_byte.push_back(ch);
      end
      wr_ptr++;
    endfunction

    function void put_text(string s);
      for (int i = 0; i < s.len(); i++) put(s[i]);
    endfunction

    // Closing brace, then the terminator, which does not advance the pointer.
    function void close_text();
      put(CH_RBRACE);
      if (step_pos.size() < MAX_WRITES) begin
        step_pos.push_back(13'(wr_ptr));
        step_byte.push_back(8'h00);
      end
      state = RUN_DONE;
    endfunction

    function void take_byte(logic [7:0] c);
      if (wr_ptr == seg_start) put(CH_QUOTE);
      if (wr_ptr >= FILL_LIMIT) begin
        truncated = 1'b1;
      end else if (c == CH_BSLASH) begin
        put(CH_BSLASH);
        put(CH_BSLASH);
      end else if (c > 8'd32 && c < CH_DEL) begin
        put(c);
      end else if (c == 8'h00) begin
        put(CH_QUOTE);
        put(CH_SPACE);
        seg_start = wr_ptr;
      end else begin
        put(CH_BSLASH);
        put(CH_ZERO + c[7:6]);
        put(CH_ZERO + c[5:3]);
        put(CH_ZERO + c[2:0]);
      end
      if (c != 8'h00) return;
      // A NUL ends one string; the list ends rewind over a cut string.
      if (args_left != 0) begin
        args_left--;
        if (args_left == 0) begin
          if (truncated) begin
            wr_ptr = seg_start;
            put_text("... ");
          end
          put_text("} envp[]={ ");
          seg_start = wr_ptr;
          truncated = 1'b0;
        end
      end else if (env_left != 0) begin
        env_left--;
        if (env_left == 0 && truncated) begin
          wr_ptr = seg_start;
          put_text("... ");
        end
      end
      if (args_left == 0 && env_left == 0) close_text();
    endfunction

    function void note_input(logic [1:0] op, logic [7:0] b);
      write_beat_t beat;
      int n;
      step_pos.delete();
      step_byte.delete();
      case (op)
        OP_START: begin
          args_left = arg_count;
          env_left = env_count;
          wr_ptr = hdr_len;
          truncated = 1'b0;
          if (args_left == 0) put_text("} envp[]={ ");
          seg_start = wr_ptr;
          state = RUN_ACTIVE;
          if (args_left == 0 && env_left == 0) close_text();
        end
        OP_DATA: if (state == RUN_ACTIVE) take_byte(b);
        OP_FAIL: if (state == RUN_ACTIVE) state = RUN_FAILED;
        default: ;
      endcase
      // A step that writes nothing still yields one status beat.
      n = (step_pos.size() == 0) ? 1 : step_pos.size();
      for (int k = 0; k < n; k++) begin
        beat.wr       = step_pos.size() != 0;
        beat.pos      = beat.wr ? step_pos[k] : 13'd0;
        beat.data     = beat.wr ? step_byte[k] : 8'd0;
        beat.last     = (k == n - 1);
        beat.finished = (state == RUN_DONE);
        beat.failed   = (state == RUN_FAILED);
        beat.flen     = (state == RUN_DONE) ? 13'(wr_ptr) : 13'd0;
        beat.args     = 16'(args_left);
        beat.envs     = 16'(env_left);
        expected_writes.push_back(beat);
      end
    endfunction

    function void field_diff(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= PRINT_LIMIT)
          $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      end
    endfunction

    function void check_write(write_beat_t got);
      write_beat_t want;
      if (expected_writes.size() == 0) begin
        errors++;
        if (errors <= PRINT_LIMIT)
          $display("%0t: result beat with nothing expected, expected none got %h", $time, got);
        return;
      end
      want = expected_writes.pop_front();
      field_diff("write_valid", want.wr, got.wr);
      field_diff("write_position", want.pos, got.pos);
      field_diff("write_byte", want.data, got.data);
      field_diff("last", want.last, got.last);
      field_diff("finished", want.finished, got.finished);
      field_diff("failed", want.failed, got.failed);
      field_diff("final_length", want.flen, got.flen);
      field_diff("arguments_remaining", want.args, got.args);
      field_diff("environment_remaining", want.envs, got.envs);
    endfunction

    function int pending();
      return expected_writes.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] data_byte
  logic [1:0]  in_tuser = OP_START; // [1:0] op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;          // [12:0] position, [20:13] byte, [21] finished,
                                   // [22] failed, [35:23] final_length,
                                   // [51:36] args left, [67:52] env left
  logic        out_tuser;          // [0] write_valid
  logic        out_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  write_beat_t out_beat;
  escape_writes_checker escape_check = new;

  // Traffic shaping: percentages of idle sender cycles and stalled receiver
  // cycles, plus a request counter for one long receiver hold-off.
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  argument_area_escape_encoder_top #(
    .BUFFER_BYTES (BUF_BYTES),
    .RESERVE_BYTES(RESERVE)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  assign out_beat = {out_tuser, out_tdata[12:0], out_tdata[20:13], out_tlast,
                     out_tdata[21], out_tdata[22], out_tdata[35:23],
                     out_tdata[51:36], out_tdata[67:52]};

  // Both monitors sample at the rising edge, before any flop or driver update
  // of that edge lands, so a beat is seen exactly when it is accepted.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) escape_check.note_input(in_tuser, in_tdata);
    if (rst_n && out_tvalid && out_tready) escape_check.check_write(out_beat);
  end

  // Receiver: random stalls, or a long hold-off when one has been requested.
  // The hold-off is counted here so that the sender keeps offering beats and
  // the descriptor queue fills up behind it.
  always @(posedge clk) begin
    if (hold_requests != hold_taken) begin
      hold_taken = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: ends the run when no beat moves on either side for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offers one input beat and returns at the edge where it is accepted. The
  // valid is only lowered when a gap is inserted, so back-to-back beats never
  // see valid dropped and raised within the same time step.
  task automatic send(input logic [1:0] op, input logic [7:0] b);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Stops offering input and waits until every predicted beat has arrived.
  // Every input beat yields at least one result, so the slack only covers
  // pipeline settling before a register write.
  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (escape_check.pending() != 0);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Register writes go back to back: each access cycle is followed directly
  // by the next setup cycle, and the bus is released after the last one.
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    escape_check.set_reg(idx, val);
  endtask

  task automatic program_regs(input logic [15:0] argc, input logic [15:0] envc,
                              input logic [7:0] hdr);
    apb_write(REG_ARG_COUNT, {16'd0, argc});
    apb_write(REG_ENV_COUNT, {16'd0, envc});
    apb_write(REG_HDR_LEN, {24'd0, hdr});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Non-NUL raw byte, weighted toward the classes the escaper treats apart.
  function automatic logic [7:0] raw_byte();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return 8'($urandom_range(33, 126));
    else if (pick < 50) return CH_BSLASH;
    else if (pick < 62) return 8'($urandom_range(1, 32));
    else if (pick < 75) return 8'($urandom_range(127, 255));
    else return 8'($urandom_range(1, 255));
  endfunction

  // A start beat followed by NUL-terminated strings of random content. Now
  // and then the area is broken off, aborted by a read failure or salted
  // with the unused input kind; a stray beat may follow the area.
  task automatic send_area(input int strings);
    int len;
    send(OP_START, 8'($urandom));
    for (int s = 0; s < strings; s++) begin
      len = $urandom_range(0, 6);
      for (int j = 0; j < len; j++) send(OP_DATA, raw_byte());
      send(OP_DATA, 8'h00);
      case ($urandom_range(0, 39))
        0: send(OP_FAIL, 8'($urandom));
        1: send(OP_UNUSED, 8'($urandom));
        2: return;
        default: ;
      endcase
    end
    if ($urandom_range(3) == 0) send($urandom_range(1) ? OP_DATA : OP_FAIL, 8'($urandom));
  endtask

  // Directed beats: ignored kinds in every phase, each escape class and the
  // byte extremes, restarts, an empty string, and the register extremes.
  task automatic run_directed();
    program_regs(16'd1, 16'd1, 8'd0);
    send(OP_FAIL, 8'hA5);
    send(OP_DATA, 8'h41);
    send(OP_START, 8'hFF);
    send(OP_DATA, 8'h21);
    send(OP_DATA, 8'h7E);
    send(OP_DATA, CH_BSLASH);
    send(OP_DATA, CH_SPACE);
    send(OP_DATA, CH_DEL);
    send(OP_DATA, 8'hFF);
    send(OP_DATA, 8'h01);
    send(OP_DATA, 8'h00);
    send(OP_DATA, 8'h00);
    send(OP_DATA, 8'h41);
    send(OP_FAIL, 8'h00);
    send(OP_UNUSED, 8'h5A);
    send(OP_START, 8'h00);
    send(OP_DATA, 8'h78);
    send(OP_FAIL, 8'h00);
    send(OP_DATA, 8'h79);
    send(OP_FAIL, 8'h00);
    send(OP_START, 8'h00);
    wait_results_done();
    // Both lists empty: separator, brace and terminator from the start beat.
    program_regs(16'd0, 16'd0, 8'd255);
    send(OP_START, 8'h00);
    wait_results_done();
    program_regs(16'd0, 16'd1, 8'd0);
    send(OP_START, 8'h00);
    send(OP_DATA, 8'h61);
    send(OP_DATA, 8'h00);
    wait_results_done();
    program_regs(16'hFFFF, 16'hFFFF, 8'd255);
    send(OP_START, 8'h00);
    send(OP_DATA, 8'h00);
    send(OP_UNUSED, 8'hC3);
    wait_results_done();
  endtask

  task automatic run_random_phase(input int idle, input int stall, input bit hold_off,
                                  input bit pause_mid);
    int argc;
    int envc;
    int first_item;
    send_idle_pct = idle;
    stall_pct <= stall;
    for (int setting = 0; setting < 2; setting++) begin
      argc = $urandom_range(0, 3);
      envc = $urandom_range(0, 3);
      program_regs(16'(argc), 16'(envc), 8'($urandom_range(0, 255)));
      if (hold_off && setting == 0) hold_requests <= hold_requests + 1;
      first_item = items_sent;
      while (items_sent - first_item < 26) begin
        send_area(argc + envc);
        // Sender pause until the output side has caught up completely.
        if (pause_mid && setting == 0 && items_sent - first_item < 12) wait_results_done();
      end
      wait_results_done();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random_phase(0, 0, 1'b1, 1'b0);
    run_random_phase(74, 0, 1'b0, 1'b1);
    run_random_phase(0, 74, 1'b0, 1'b0);
    run_random_phase(32, 32, 1'b0, 1'b0);
    wait_results_done();
    if (escape_check.errors == 0 && escape_check.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
